FILE: sv/solar_pump_hysteresis_controller_core_macros.svh
// assertion helpers for the pump controller core
// they sample on clk and are held off while rst_n is low
`ifndef SOLAR_PUMP_HYSTERESIS_CONTROLLER_CORE_MACROS_SVH
`define SOLAR_PUMP_HYSTERESIS_CONTROLLER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SPHC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sphc: same-cycle check failed");

`define SPHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sphc: next-cycle check failed");

`else

`define SPHC_ASSERT_SAME(lbl, ante, cons)

`define SPHC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: sv/sphc_pkg.sv
package sphc_pkg;

  localparam int DUTY_BITS = 8;

  typedef logic signed [11:0]          temp_t;
  typedef logic signed [12:0]          delta_t;
  typedef logic [DUTY_BITS-1:0]        duty_t;
  typedef logic [12:0]                 cfg_data_t;

  typedef enum logic [2:0] {
    REG_FROST_ON    = 3'd0,
    REG_FROST_OFF   = 3'd1,
    REG_LOAD_START  = 3'd2,
    REG_LOAD_STOP   = 3'd3,
    REG_HEAT_START  = 3'd4,
    REG_HEAT_STOP   = 3'd5,
    REG_HEAT_ENABLE = 3'd6
  } reg_idx_t;

  localparam temp_t  FROST_ON_RST    = 12'sd32;
  localparam temp_t  FROST_OFF_RST   = 12'sd80;
  localparam delta_t LOAD_START_RST  = 13'sd128;
  localparam delta_t LOAD_STOP_RST   = 13'sd48;
  localparam delta_t HEAT_START_RST  = 13'sd80;
  localparam delta_t HEAT_STOP_RST   = 13'sd32;

  localparam duty_t DUTY_MAX   = {DUTY_BITS{1'b1}};
  localparam duty_t HALF_POWER = 8'd150;

  // duty = delta * 51 / 80 done as delta * 41780 >> 16, exact for deltas below the clamp
  localparam int   SCALE_SHIFT = 16;
  localparam int   DMAG_BITS   = 9;
  localparam logic [SCALE_SHIFT-1:0] SCALE_RECIP = 16'd41780;
  // smallest delta whose scaled duty passes full scale
  localparam delta_t CLAMP_DELTA = 13'sd402;

  typedef struct packed {
    temp_t panel_temp;
    temp_t store_low_temp;
    temp_t store_high_temp;
    temp_t floor_temp;
    logic  read_error;
  } sample_t;

  typedef struct packed {
    temp_t  frost_on_temp;
    temp_t  frost_off_temp;
    delta_t load_start_delta;
    delta_t load_stop_delta;
    delta_t heat_start_delta;
    delta_t heat_stop_delta;
    logic   heating_enable;
  } cfg_t;

  typedef struct packed {
    logic  frost;
    logic  loading;
    logic  heating;
    duty_t panel_duty;
    duty_t floor_duty;
  } state_t;

endpackage

FILE: sv/sphc_if.sv
interface sphc_in_if;
  logic                  valid;
  logic                  ready;
  sphc_pkg::temp_t       panel_temp;
  sphc_pkg::temp_t       store_low_temp;
  sphc_pkg::temp_t       store_high_temp;
  sphc_pkg::temp_t       floor_temp;
  logic                  read_error;

  modport source (output valid, panel_temp, store_low_temp, store_high_temp, floor_temp,
                  read_error, input ready);
  modport sink   (input valid, panel_temp, store_low_temp, store_high_temp, floor_temp,
                  read_error, output ready);
endinterface

interface sphc_out_if;
  logic                  valid;
  logic                  ready;
  sphc_pkg::duty_t       panel_duty;
  sphc_pkg::duty_t       floor_duty;
  logic                  frost_active;
  logic                  loading_active;
  logic                  heating_active;

  modport source (output valid, panel_duty, floor_duty, frost_active, loading_active,
                  heating_active, input ready);
  modport sink   (input valid, panel_duty, floor_duty, frost_active, loading_active,
                  heating_active, output ready);
endinterface

interface sphc_cfg_if;
  logic                  valid;
  logic                  ready;
  logic [2:0]            index;
  sphc_pkg::cfg_data_t   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/sphc_step.sv
module sphc_step (
  input  sphc_pkg::sample_t sample,
  input  sphc_pkg::cfg_t    cfg,
  input  sphc_pkg::state_t  state,
  output sphc_pkg::state_t  state_nxt
);

  sphc_pkg::delta_t                                   dpanel;
  sphc_pkg::delta_t                                   dfloor;
  logic [sphc_pkg::DMAG_BITS+sphc_pkg::SCALE_SHIFT-1:0] prod;
  sphc_pkg::duty_t                                    scaled;

  assign dpanel = sphc_pkg::delta_t'(sample.panel_temp)
                - sphc_pkg::delta_t'(sample.store_low_temp);
  assign dfloor = sphc_pkg::delta_t'(sample.store_high_temp)
                - sphc_pkg::delta_t'(sample.floor_temp);

  // reciprocal multiply, only the low bits of the delta matter below the clamp
  assign prod = (sphc_pkg::DMAG_BITS+sphc_pkg::SCALE_SHIFT)'(dpanel[sphc_pkg::DMAG_BITS-1:0])
              * (sphc_pkg::DMAG_BITS+sphc_pkg::SCALE_SHIFT)'(sphc_pkg::SCALE_RECIP);

  always_comb begin
    priority if (dpanel <= 13'sd0) begin
      scaled = '0;
    end else if (dpanel >= sphc_pkg::CLAMP_DELTA) begin
      scaled = sphc_pkg::DUTY_MAX;
    end else begin
      scaled = prod[sphc_pkg::SCALE_SHIFT +: sphc_pkg::DUTY_BITS];
    end
  end

  always_comb begin
    state_nxt = state;

    // panel pump chain, first match wins
    priority if (!state.frost && (sample.panel_temp < cfg.frost_on_temp)) begin
      state_nxt.frost      = 1'b1;
      state_nxt.panel_duty = sphc_pkg::HALF_POWER;
    end else if (state.frost && (sample.panel_temp > cfg.frost_off_temp)) begin
      state_nxt.frost      = 1'b0;
      state_nxt.panel_duty = '0;
    end else if (!state.loading && (dpanel > cfg.load_start_delta)) begin
      state_nxt.loading    = 1'b1;
      state_nxt.panel_duty = scaled;
    end else if (state.loading && (dpanel < cfg.load_stop_delta)) begin
      state_nxt.loading    = 1'b0;
      state_nxt.panel_duty = '0;
    end else if (state.loading) begin
      state_nxt.panel_duty = scaled;
    end else begin
      // panel duty held
    end

    // floor pump chain
    priority if (state.heating && !cfg.heating_enable) begin
      state_nxt.heating    = 1'b0;
      state_nxt.floor_duty = '0;
    end else if (cfg.heating_enable && !state.heating && (dfloor > cfg.heat_start_delta)) begin
      state_nxt.heating    = 1'b1;
      state_nxt.floor_duty = sphc_pkg::HALF_POWER;
    end else if (state.heating && (dfloor < cfg.heat_stop_delta)) begin
      state_nxt.heating    = 1'b0;
      state_nxt.floor_duty = '0;
    end else begin
      // floor duty held
    end
  end

endmodule

FILE: sv/solar_pump_hysteresis_controller_core.sv
// channel   dir  transfer when        payload
// in_if     in   valid && ready      panel, store low, store high, floor temps, read_error
// out_if    out  valid && ready      panel_duty, floor_duty, frost/loading/heating flags
// cfg_if    in   valid && ready      register index, write data (always ready)
//
// one sample per cycle sustained while out_if is ready; a result passes the input register
// and then the controller state, which is also the result register
// samples flagged with read_error are dropped at the input register, no result
// reset clears the flags and duties and loads the default thresholds
// a stalled result holds the state; the input register still takes one more sample

`include "solar_pump_hysteresis_controller_core_macros.svh"

module solar_pump_hysteresis_controller_core (
  input  logic          clk,
  input  logic          rst_n,
  sphc_in_if.sink       in_if,
  sphc_out_if.source    out_if,
  sphc_cfg_if.sink      cfg_if
);

  sphc_pkg::sample_t sample_r;
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  sphc_pkg::cfg_t    cfg_r;
  sphc_pkg::cfg_t    cfg_nxt;
  sphc_pkg::state_t  state_r;
  sphc_pkg::state_t  state_nxt;
  sphc_pkg::state_t  step_state;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_free;
  logic              out_load;
  logic              s1_drain;
  logic              in_take;

  assign out_free = !out_valid_r || out_if.ready;
  assign out_load = s1_valid_r && !sample_r.read_error && out_free;
  assign s1_drain = s1_valid_r && (sample_r.read_error || out_free);
  assign in_if.ready = !s1_valid_r || s1_drain;
  assign in_take  = in_if.valid && in_if.ready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_drain);
  assign out_valid_nxt = out_load || (out_valid_r && !out_if.ready);
  assign state_nxt     = out_load ? step_state : state_r;

  sphc_step u_step (
    .sample    (sample_r),
    .cfg       (cfg_r),
    .state     (state_r),
    .state_nxt (step_state)
  );

  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_r.panel_temp      <= in_if.panel_temp;
      sample_r.store_low_temp  <= in_if.store_low_temp;
      sample_r.store_high_temp <= in_if.store_high_temp;
      sample_r.floor_temp      <= in_if.floor_temp;
      sample_r.read_error      <= in_if.read_error;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid && cfg_if.ready) begin
      unique case (sphc_pkg::reg_idx_t'(cfg_if.index))
        sphc_pkg::REG_FROST_ON:    cfg_nxt.frost_on_temp    = sphc_pkg::temp_t'(cfg_if.data[11:0]);
        sphc_pkg::REG_FROST_OFF:   cfg_nxt.frost_off_temp   = sphc_pkg::temp_t'(cfg_if.data[11:0]);
        sphc_pkg::REG_LOAD_START:  cfg_nxt.load_start_delta = sphc_pkg::delta_t'(cfg_if.data);
        sphc_pkg::REG_LOAD_STOP:   cfg_nxt.load_stop_delta  = sphc_pkg::delta_t'(cfg_if.data);
        sphc_pkg::REG_HEAT_START:  cfg_nxt.heat_start_delta = sphc_pkg::delta_t'(cfg_if.data);
        sphc_pkg::REG_HEAT_STOP:   cfg_nxt.heat_stop_delta  = sphc_pkg::delta_t'(cfg_if.data);
        sphc_pkg::REG_HEAT_ENABLE: cfg_nxt.heating_enable   = cfg_if.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      cfg_r.frost_on_temp    <= sphc_pkg::FROST_ON_RST;
      cfg_r.frost_off_temp   <= sphc_pkg::FROST_OFF_RST;
      cfg_r.load_start_delta <= sphc_pkg::LOAD_START_RST;
      cfg_r.load_stop_delta  <= sphc_pkg::LOAD_STOP_RST;
      cfg_r.heat_start_delta <= sphc_pkg::HEAT_START_RST;
      cfg_r.heat_stop_delta  <= sphc_pkg::HEAT_STOP_RST;
      cfg_r.heating_enable   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  // the controller state is the result register
  assign out_if.valid          = out_valid_r;
  assign out_if.panel_duty     = state_r.panel_duty;
  assign out_if.floor_duty     = state_r.floor_duty;
  assign out_if.frost_active   = state_r.frost;
  assign out_if.loading_active = state_r.loading;
  assign out_if.heating_active = state_r.heating;

  // floor pump is either off or at half power, matching its flag
  `SPHC_ASSERT_SAME(a_floor_duty_flag, 1'b1,
    (state_r.heating && state_r.floor_duty == sphc_pkg::HALF_POWER) ||
    (!state_r.heating && state_r.floor_duty == '0))
  // with neither frost protection nor loading the panel pump is off
  `SPHC_ASSERT_SAME(a_panel_idle_off, !state_r.frost && !state_r.loading,
    state_r.panel_duty == '0)
  // the state moves only with a result transfer into the output register
  `SPHC_ASSERT_NEXT(a_state_only_on_load, !out_load, state_r == $past(state_r))

endmodule
